// ===== rtl/core/skya_pkg.sv =====
// ----------------------------------------------------------------------------
// skya_pkg: shared types and constants of the skyline atlas allocator
// Sizes of the atlas, command and status codes, cell control, FSM states.
// ----------------------------------------------------------------------------
package skya_pkg;

   localparam int ATLAS_WIDTH  = 1024;
   localparam int ATLAS_HEIGHT = 1024;
   localparam int MAX_ATLASES  = 4;

   localparam int COL_W = $clog2(ATLAS_WIDTH);
   localparam int HGT_W = $clog2(ATLAS_HEIGHT + 1);
   localparam int ATL_W = $clog2(MAX_ATLASES + 1);
   localparam int SUM_W = 13;

   localparam logic [1:0] FUNC_BEGIN = 2'd0;
   localparam logic [1:0] FUNC_ALLOC = 2'd1;
   localparam logic [1:0] FUNC_END   = 2'd2;
   localparam logic [1:0] FUNC_NOP   = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_NOFIT = 2'd1;
   localparam logic [1:0] STAT_OVER  = 2'd2;

   typedef struct packed {
      logic             clear;
      logic             load;
      logic             acc;
      logic             shift;
      logic             write;
      logic [COL_W-1:0] lo;
      logic [COL_W-1:0] hi;
      logic [HGT_W-1:0] new_h;
   } skya_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ACC,
      ST_SCAN,
      ST_CHECK,
      ST_FAIL,
      ST_DONE
   } skya_state_type;

endpackage

// ===== rtl/core/skya_if.sv =====
// ----------------------------------------------------------------------------
// skya_if: request and response channels of the skyline atlas allocator
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface skya_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [10:0] rect_width;
   logic [10:0] rect_height;

   modport source (output valid, func, rect_width, rect_height, input ready);
   modport sink   (input valid, func, rect_width, rect_height, output ready);
endinterface

interface skya_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [9:0]  pos_x;
   logic [10:0] pos_y;
   logic [2:0]  atlas_number;

   modport source (output valid, status, pos_x, pos_y, atlas_number, input ready);
   modport sink   (input valid, status, pos_x, pos_y, atlas_number, output ready);
endinterface

// ===== rtl/core/skya_cell.sv =====
// ----------------------------------------------------------------------------
// skya_cell: one skyline column
// Holds the column height, a travelling height copy and a window maximum.
// ----------------------------------------------------------------------------
module skya_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  skya_pkg::skya_ctrl_type     ctrl,
   input  logic [skya_pkg::COL_W-1:0]  idx,
   input  logic [skya_pkg::HGT_W-1:0]  s_in,
   input  logic [skya_pkg::HGT_W-1:0]  m_in,
   output logic [skya_pkg::HGT_W-1:0]  s_out,
   output logic [skya_pkg::HGT_W-1:0]  m_out
);
   import skya_pkg::*;

   logic [HGT_W-1:0] h_ff;
   logic [HGT_W-1:0] s_ff;
   logic [HGT_W-1:0] m_ff;
   logic             hit;

   assign hit   = (idx >= ctrl.lo) && (idx < ctrl.hi);
   assign s_out = s_ff;
   assign m_out = m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= '0;
      end else if (ctrl.write && hit) begin
         h_ff <= ctrl.new_h;
      end else if (ctrl.clear) begin
         h_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         s_ff <= h_ff;
         m_ff <= '0;
      end else if (ctrl.acc) begin
         // fold in the column now passing, then pull the next one in
         if (s_ff > m_ff) m_ff <= s_ff;
         s_ff <= s_in;
      end else if (ctrl.shift) begin
         m_ff <= m_in;
      end
   end

endmodule

// ===== rtl/core/skyline_atlas_allocator_top.sv =====
// ----------------------------------------------------------------------------
// skyline_atlas_allocator_top: skyline rectangle allocator for texture atlases
// Row of column cells plus a sequencer for begin, allocate and end.
// ----------------------------------------------------------------------------
// Usage: send one item on req_chan (func, rect_width, rect_height); exactly
// one item comes back on rsp_chan (status, pos_x, pos_y, atlas_number).
// One item is worked on at a time. Begin, end and no-op go from accept through
// the EXEC and DONE states to response valid. An allocate first builds every
// window maximum in the column row in the ACC state, then the maxima shift out
// of the row, one candidate start column at a time, past the minimum search in
// the SCAN state; a retry on a fresh atlas adds the FAIL state. Widths of zero
// or of the full atlas and the retry on a fresh atlas skip the scan. The next
// item can be accepted in the same cycle as the response turns valid.
// Reset clears every column height and the atlas count.
// A finished response waits in the output register while the receiver stalls;
// the next item is accepted meanwhile and its response is held until the
// output register frees.
// ----------------------------------------------------------------------------
module skyline_atlas_allocator_top (
   input  logic clock,
   input  logic reset,
   skya_req_if.sink   req_chan,
   skya_rsp_if.source rsp_chan
);
   import skya_pkg::*;

   skya_state_type   state_ff, state_in;
   logic [1:0]       func_ff, func_in;
   logic [10:0]      w_ff, w_in;
   logic [10:0]      h_ff, h_in;
   logic [ATL_W-1:0] atlas_ff, atlas_in;
   logic [COL_W-1:0] cnt_ff, cnt_in;
   logic [HGT_W-1:0] best_ff, best_in;
   logic [COL_W-1:0] bx_ff, bx_in;
   logic             found_ff, found_in;
   logic [1:0]       rs_ff, rs_in;
   logic [9:0]       rx_ff, rx_in;
   logic [10:0]      ry_ff, ry_in;
   logic             ov_ff, ov_in;
   logic [1:0]       os_ff, os_in;
   logic [9:0]       ox_ff, ox_in;
   logic [10:0]      oy_ff, oy_in;
   logic [2:0]       oa_ff, oa_in;

   skya_ctrl_type    ctrl;
   logic [HGT_W-1:0] s_bus [ATLAS_WIDTH+1];
   logic [HGT_W-1:0] m_bus [ATLAS_WIDTH+1];
   logic [SUM_W-1:0] top_sum;
   logic [COL_W-1:0] scan_lim;
   logic [ATL_W:0]   atlas_inc;

   assign s_bus[ATLAS_WIDTH] = '0;
   assign m_bus[ATLAS_WIDTH] = '0;

   for (genvar i = 0; i < ATLAS_WIDTH; i++) begin : g_col
      skya_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .idx   (COL_W'(i)),
         .s_in  (s_bus[i+1]),
         .m_in  (m_bus[i+1]),
         .s_out (s_bus[i]),
         .m_out (m_bus[i])
      );
   end

   assign top_sum   = SUM_W'(best_ff) + SUM_W'(h_ff);
   assign scan_lim  = COL_W'(ATLAS_WIDTH - 1) - COL_W'(w_ff);
   assign atlas_inc = (ATL_W+1)'(atlas_ff) + 1'b1;

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = ov_ff;
   assign rsp_chan.status       = os_ff;
   assign rsp_chan.pos_x        = ox_ff;
   assign rsp_chan.pos_y        = oy_ff;
   assign rsp_chan.atlas_number = oa_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         atlas_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         atlas_ff <= atlas_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      cnt_ff   <= cnt_in;
      best_ff  <= best_in;
      bx_ff    <= bx_in;
      found_ff <= found_in;
      rs_ff    <= rs_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      os_ff    <= os_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      oa_ff    <= oa_in;
   end

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      atlas_in = atlas_ff;
      cnt_in   = cnt_ff;
      best_in  = best_ff;
      bx_in    = bx_ff;
      found_in = found_ff;
      rs_in    = rs_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      ov_in    = ov_ff && !rsp_chan.ready;
      os_in    = os_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oa_in    = oa_ff;
      ctrl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               func_in  = req_chan.func;
               w_in     = req_chan.rect_width;
               h_in     = req_chan.rect_height;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rs_in    = STAT_OK;
            rx_in    = '0;
            ry_in    = '0;
            state_in = ST_DONE;
            unique case (func_ff)
               FUNC_BEGIN: begin
                  ctrl.clear = 1'b1;
                  atlas_in   = '0;
               end
               FUNC_END: begin
                  if (32'(atlas_ff) >= MAX_ATLASES) begin
                     rs_in = STAT_OVER;
                  end else begin
                     atlas_in = ATL_W'(atlas_inc);
                     if (32'(atlas_inc) >= MAX_ATLASES) rs_in = STAT_OVER;
                  end
               end
               FUNC_ALLOC: begin
                  if (32'(atlas_ff) >= MAX_ATLASES) begin
                     rs_in = STAT_OVER;
                  end else if (32'(w_ff) >= ATLAS_WIDTH) begin
                     state_in = ST_FAIL;
                  end else if (w_ff == '0) begin
                     // every start column qualifies; the last one wins
                     found_in = 1'b1;
                     best_in  = '0;
                     bx_in    = COL_W'(ATLAS_WIDTH - 1);
                     state_in = ST_CHECK;
                  end else begin
                     ctrl.load = 1'b1;
                     cnt_in    = '0;
                     state_in  = ST_ACC;
                  end
               end
               default: ;
            endcase
         end
         ST_ACC: begin
            ctrl.acc = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == COL_W'(w_ff - 11'd1)) begin
               cnt_in   = '0;
               best_in  = HGT_W'(ATLAS_HEIGHT);
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // window maxima leave the row at column zero, lowest start first
            ctrl.shift = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (m_bus[0] < best_ff) begin
               best_in  = m_bus[0];
               bx_in    = cnt_ff;
               found_in = 1'b1;
            end
            if (cnt_ff == scan_lim) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (found_ff && (32'(top_sum) <= ATLAS_HEIGHT)) begin
               ctrl.write = 1'b1;
               ctrl.lo    = bx_ff;
               ctrl.hi    = bx_ff + COL_W'(w_ff);
               ctrl.new_h = HGT_W'(top_sum);
               rs_in      = STAT_OK;
               rx_in      = 10'(bx_ff);
               ry_in      = 11'(best_ff);
               state_in   = ST_DONE;
            end else begin
               state_in = ST_FAIL;
            end
         end
         ST_FAIL: begin
            rx_in    = '0;
            ry_in    = '0;
            state_in = ST_DONE;
            if (32'(atlas_inc) >= MAX_ATLASES) begin
               // keep the skyline; hold the count at its limit
               atlas_in = ATL_W'(MAX_ATLASES);
               rs_in    = STAT_OVER;
            end else begin
               atlas_in   = ATL_W'(atlas_inc);
               ctrl.clear = 1'b1;
               if ((32'(w_ff) >= ATLAS_WIDTH) || (32'(h_ff) > ATLAS_HEIGHT)) begin
                  rs_in = STAT_NOFIT;
               end else begin
                  // fresh atlas: place at the first column, row zero
                  ctrl.write = 1'b1;
                  ctrl.lo    = '0;
                  ctrl.hi    = COL_W'(w_ff);
                  ctrl.new_h = HGT_W'(h_ff);
                  rs_in      = STAT_OK;
                  rx_in      = (w_ff == '0) ? 10'(ATLAS_WIDTH - 1) : 10'd0;
               end
            end
         end
         ST_DONE: begin
            if (!ov_ff || rsp_chan.ready) begin
               ov_in    = 1'b1;
               os_in    = rs_ff;
               ox_in    = rx_ff;
               oy_in    = ry_ff;
               oa_in    = 3'(atlas_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_atlas_range: assert property (@(posedge clock) disable iff (reset)
      32'(atlas_ff) <= MAX_ATLASES)
      else $error("atlas count beyond limit");

   a_acc_width: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (w_ff != '0) && (32'(w_ff) < ATLAS_WIDTH))
      else $error("window build with invalid width");

   a_found_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && found_ff && func_ff == FUNC_ALLOC && w_ff != '0)
         |-> (32'(best_ff) < ATLAS_HEIGHT))
      else $error("found window with full height");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= scan_lim))
      else $error("scan ran past last start column");

endmodule
